### design/palette_store_with_border_select_core_assert.svh
// Assertion macros used by the checker of the palette store block.
`ifndef PALETTE_STORE_WITH_BORDER_SELECT_CORE_ASSERT_SVH
`define PALETTE_STORE_WITH_BORDER_SELECT_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define PSSB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PSSB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/pssb_pkg.sv
// Types, constants and helper functions of the palette store block.
package pssb_pkg;

	localparam int IDX_W     = 8;
	localparam int LEVEL_W   = 16;
	localparam int CH_W      = 6;
	localparam int ENTRY_W   = 3 * CH_W;
	localparam int CH_SHIFT  = 10;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CH_W-1:0] CH_FULL    = 6'd63;
	localparam logic [CH_W-1:0] CH_LCD_MAX = 6'd62;

	localparam logic [CFG_IDX_W-1:0] REG_LCD_AVOID_WHITE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PORT_WRITE_ENABLE = 8'd1;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic             nz;
		logic             last;
		logic             pw;
	} qent_t;

	// Cut a 16-bit level to 6 bits, optionally keeping clear of full white.
	function automatic logic [CH_W-1:0] to_six(input logic [LEVEL_W-1:0] lvl, input logic lcd);
		logic [CH_W-1:0] v;
		v = lvl[LEVEL_W-1:CH_SHIFT];
		if (lcd && v == CH_FULL) begin
			v = CH_LCD_MAX;
		end
		return v;
	endfunction

	// True when every channel of e is strictly below that of b.
	function automatic logic darker(input logic [ENTRY_W-1:0] e, input logic [ENTRY_W-1:0] b);
		return (e[3*CH_W-1:2*CH_W] < b[3*CH_W-1:2*CH_W]) &&
			(e[2*CH_W-1:CH_W] < b[2*CH_W-1:CH_W]) &&
			(e[CH_W-1:0] < b[CH_W-1:0]);
	endfunction

endpackage

### design/pssb_ifs.sv
// Channel interfaces of the palette store block: items, results and configuration.
interface pssb_item_if;
	logic                          valid;
	logic                          ready;
	logic [pssb_pkg::IDX_W-1:0]    entry_index;
	logic [pssb_pkg::LEVEL_W-1:0]  red_level;
	logic [pssb_pkg::LEVEL_W-1:0]  green_level;
	logic [pssb_pkg::LEVEL_W-1:0]  blue_level;
	logic                          batch_end;

	modport source (output valid, entry_index, red_level, green_level, blue_level, batch_end,
		input ready);
	modport sink (input valid, entry_index, red_level, green_level, blue_level, batch_end,
		output ready);
endinterface

interface pssb_result_if;
	logic                       valid;
	logic                       ready;
	logic [pssb_pkg::IDX_W-1:0] dac_index;
	logic [pssb_pkg::CH_W-1:0]  dac_red;
	logic [pssb_pkg::CH_W-1:0]  dac_green;
	logic [pssb_pkg::CH_W-1:0]  dac_blue;
	logic                       port_write;
	logic [pssb_pkg::IDX_W-1:0] border_index;
	logic                       border_changed;

	modport source (output valid, dac_index, dac_red, dac_green, dac_blue, port_write,
		border_index, border_changed, input ready);
	modport sink (input valid, dac_index, dac_red, dac_green, dac_blue, port_write,
		border_index, border_changed, output ready);
endinterface

interface pssb_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pssb_pkg::CFG_IDX_W-1:0] index;
	logic [pssb_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/pssb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pssb_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### design/pssb_queue.sv
// Short queue of classified items between the front and back parts.
module pssb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            push_ready,
	input  pssb_pkg::qent_t push_data,
	output logic            pop_valid,
	input  logic            pop,
	output pssb_pkg::qent_t pop_data
);
	localparam int PW = $clog2(pssb_pkg::QUEUE_DEPTH);

	pssb_pkg::qent_t mem_q [pssb_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [PW:0]     count_q;

	assign push_ready = count_q < (PW+1)'(pssb_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(pssb_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(pssb_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end
endmodule

### design/pssb_front.sv
// Front part: configuration registers, channel conversion and queue push.
module pssb_front (
	input  logic            clk,
	input  logic            arst_n,
	pssb_item_if.sink       items,
	pssb_cfg_if.sink        cfg,
	output logic            q_push,
	output pssb_pkg::qent_t q_data,
	input  logic            q_ready
);
	logic lcd_q;
	logic pwe_q;

	assign cfg.ready   = 1'b1;
	assign items.ready = q_ready;
	assign q_push      = items.valid && q_ready;

	always_comb begin
		q_data.idx   = items.entry_index;
		q_data.red   = pssb_pkg::to_six(items.red_level, lcd_q);
		q_data.green = pssb_pkg::to_six(items.green_level, lcd_q);
		q_data.blue  = pssb_pkg::to_six(items.blue_level, lcd_q);
		q_data.nz    = (items.red_level | items.green_level | items.blue_level) != '0;
		q_data.last  = items.batch_end;
		q_data.pw    = pwe_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_q <= 1'b0;
			pwe_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pssb_pkg::REG_LCD_AVOID_WHITE:   lcd_q <= cfg.data[0];
				pssb_pkg::REG_PORT_WRITE_ENABLE: pwe_q <= cfg.data[0];
				default: ;
			endcase
		end
	end
endmodule

### design/pssb_back.sv
// Back part: border tracking, palette writes, border search and result register.
module pssb_back #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  pssb_pkg::qent_t q_data,
	output logic            q_pop,
	pssb_result_if.source   results
);
	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int EW = pssb_pkg::ENTRY_W;
	localparam int IW = pssb_pkg::IDX_W;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_BEST = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]         state_q;
	logic [IW-1:0]      border_q;
	logic               hit_q;
	logic               nz_q;
	pssb_pkg::qent_t    cur_q;
	logic [EW-1:0]      best_q;
	logic [IW-1:0]      chosen_q;
	logic [AW-1:0]      cnt_q;
	logic               issuing_q;
	logic               rd_vld_s1;
	logic               rd_best_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic               rd_ent_vld_s1;
	logic [PALETTE_DEPTH-1:0] vld_q;

	logic               out_vld_q;
	logic [IW-1:0]      out_idx_q;
	logic [pssb_pkg::CH_W-1:0] out_red_q;
	logic [pssb_pkg::CH_W-1:0] out_green_q;
	logic [pssb_pkg::CH_W-1:0] out_blue_q;
	logic               out_pw_q;
	logic [IW-1:0]      out_border_q;
	logic               out_chg_q;

	logic               out_free;
	logic               hit_now;
	logic               hit_eff;
	logic               nz_eff;
	logic               searching;
	logic               in_range;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [EW-1:0]      ram_wdata;
	logic [AW-1:0]      best_addr;
	logic [AW-1:0]      ram_raddr;
	logic [EW-1:0]      ram_rdata;
	logic [EW-1:0]      rd_word;
	logic               is_zero;
	logic               is_darker;
	logic [IW-1:0]      chosen_nx;
	logic               load_item;
	logic               load_fin;

	assign out_free  = !out_vld_q || results.ready;
	assign q_pop     = (state_q == ST_RUN) && q_valid && out_free;
	assign hit_now   = (q_data.idx == border_q) && !hit_q;
	assign hit_eff   = hit_q || hit_now;
	assign nz_eff    = hit_now ? q_data.nz : nz_q;
	assign searching = q_data.last && hit_eff && nz_eff;
	assign in_range  = {1'b0, q_data.idx} < (IW+1)'(PALETTE_DEPTH);
	assign ram_we    = q_pop && in_range;
	assign ram_waddr = q_data.idx[AW-1:0];
	assign ram_wdata = {q_data.red, q_data.green, q_data.blue};
	assign best_addr = ({1'b0, border_q} < (IW+1)'(PALETTE_DEPTH)) ? border_q[AW-1:0] : '0;
	assign ram_raddr = (state_q == ST_BEST) ? best_addr : cnt_q;
	assign rd_word   = rd_ent_vld_s1 ? ram_rdata : '0;
	assign is_zero   = rd_word == '0;
	assign is_darker = pssb_pkg::darker(rd_word, best_q);
	assign chosen_nx = is_darker ? IW'(rd_idx_s1) : chosen_q;
	assign load_item = q_pop && !searching;
	assign load_fin  = (state_q == ST_FIN) && out_free;

	pssb_ram #(
		.WIDTH(EW),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1     <= cnt_q;
		rd_ent_vld_s1 <= vld_q[ram_raddr];
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (state_q == ST_BEST) begin
			chosen_q <= border_q;
		end else if (state_q == ST_SCAN && rd_vld_s1 && !is_zero && is_darker) begin
			chosen_q <= IW'(rd_idx_s1);
		end
		if (state_q == ST_SCAN && rd_best_s1) begin
			best_q <= rd_word;
		end else if (state_q == ST_SCAN && rd_vld_s1 && !is_zero && is_darker) begin
			best_q <= rd_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			border_q   <= '0;
			hit_q      <= 1'b0;
			nz_q       <= 1'b0;
			cnt_q      <= '0;
			issuing_q  <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_best_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= (state_q == ST_SCAN) && issuing_q;
			rd_best_s1 <= state_q == ST_BEST;
			unique case (state_q)
				ST_RUN: begin
					if (q_pop) begin
						if (q_data.last) begin
							hit_q <= 1'b0;
							nz_q  <= 1'b0;
							if (searching) begin
								state_q <= ST_BEST;
							end
						end else begin
							hit_q <= hit_eff;
							nz_q  <= nz_eff;
						end
					end
				end
				ST_BEST: begin
					cnt_q     <= AW'(PALETTE_DEPTH - 1);
					issuing_q <= 1'b1;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issuing_q && !(rd_vld_s1 && is_zero)) begin
						if (cnt_q == '0) begin
							issuing_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - AW'(1);
						end
					end
					if (rd_vld_s1) begin
						if (is_zero) begin
							border_q  <= IW'(rd_idx_s1);
							issuing_q <= 1'b0;
							state_q   <= ST_FIN;
						end else if (rd_idx_s1 == '0) begin
							border_q <= chosen_nx;
							state_q  <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_item || load_fin) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			out_idx_q    <= q_data.idx;
			out_red_q    <= q_data.red;
			out_green_q  <= q_data.green;
			out_blue_q   <= q_data.blue;
			out_pw_q     <= q_data.pw;
			out_border_q <= border_q;
			out_chg_q    <= 1'b0;
		end else if (load_fin) begin
			out_idx_q    <= cur_q.idx;
			out_red_q    <= cur_q.red;
			out_green_q  <= cur_q.green;
			out_blue_q   <= cur_q.blue;
			out_pw_q     <= cur_q.pw;
			out_border_q <= border_q;
			out_chg_q    <= 1'b1;
		end
	end

	assign results.valid          = out_vld_q;
	assign results.dac_index      = out_idx_q;
	assign results.dac_red        = out_red_q;
	assign results.dac_green      = out_green_q;
	assign results.dac_blue       = out_blue_q;
	assign results.port_write     = out_pw_q;
	assign results.border_index   = out_border_q;
	assign results.border_changed = out_chg_q;
endmodule

### design/palette_store_with_border_select_core.sv
// Top level of the palette store with border colour selection.
// Usage: each request on the items channel is one colour definition (palette index,
// three 16-bit levels and a batch end mark). Each yields exactly one request on the
// results channel: the 6-bit DAC write, the port write flag and the border index in
// force afterwards, in the order the definitions were taken.
// The cfg channel writes lcd_avoid_white (index 0) and port_write_enable (index 1);
// it is always ready. It must be written only while no definition is in flight; the
// block itself does not enforce this. Each definition is held in the queue and then
// in the result register. Throughput: one definition per cycle for ordinary writes
// while the receiver keeps taking results. A batch whose first write to the border
// entry had non-zero levels starts, at its batch end, a scan of the palette RAM, one
// entry per cycle from the top; the back part steps through ST_BEST, ST_SCAN and
// ST_FIN, loads the result and only then takes the next definition from the queue.
// The scan stops early at the first black entry. The queue keeps taking items until
// it is full. Reset: the palette reads as all black through per-entry valid flags, so
// no clearing pass is needed; the border index and batch flags return to zero.
// When the receiver stalls, the result register holds its request and the queue fills,
// after which items.ready drops.
module palette_store_with_border_select_core #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	pssb_item_if.sink     items,
	pssb_result_if.source results,
	pssb_cfg_if.sink      cfg
);
	logic            f_push;
	logic            f_ready;
	pssb_pkg::qent_t f_data;
	logic            b_valid;
	logic            b_pop;
	pssb_pkg::qent_t b_data;

	// Front part converts levels and classifies each definition.
	pssb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.cfg    (cfg),
		.q_push (f_push),
		.q_data (f_data),
		.q_ready(f_ready)
	);

	// The queue lets the front keep accepting while the back part scans.
	pssb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_ready(f_ready),
		.push_data (f_data),
		.pop_valid (b_valid),
		.pop       (b_pop),
		.pop_data  (b_data)
	);

	// Back part owns the palette, the border state and the result register.
	pssb_back #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(b_valid),
		.q_data (b_data),
		.q_pop  (b_pop),
		.results(results)
	);
endmodule

### design/pssb_checker.sv
// Port-level checker of the palette store block and its bind to the top level.
`include "palette_store_with_border_select_core_assert.svh"

module pssb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_dac_index,
	input logic [7:0] out_border_index,
	input logic       out_border_changed
);
	logic [3:0] pend_q;
	logic [7:0] last_border_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q        <= '0;
			last_border_q <= '0;
		end else begin
			if (in_acc && !out_acc) begin
				pend_q <= pend_q + 4'd1;
			end else if (out_acc && !in_acc) begin
				pend_q <= pend_q - 4'd1;
			end
			if (out_acc) begin
				last_border_q <= out_border_index;
			end
		end
	end

	`PSSB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result withdrawn while stalled")
	`PSSB_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_dac_index) && $stable(out_border_index), "stalled result changed")
	`PSSB_ASSERT(a_no_invented, out_valid |-> pend_q != 4'd0, "result without a pending definition")
	`PSSB_ASSERT(a_border_kept, out_valid && !out_border_changed |-> out_border_index == last_border_q, "border moved without a search")
endmodule

bind palette_store_with_border_select_core pssb_checker u_pssb_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (items.valid),
	.in_ready          (items.ready),
	.out_valid         (results.valid),
	.out_ready         (results.ready),
	.out_dac_index     (results.dac_index),
	.out_border_index  (results.border_index),
	.out_border_changed(results.border_changed)
);
